/* rtl/core/ipul_pkg.sv */
package ipul_pkg;

   localparam int POSITION_BITS = 16;
   localparam int EXT_W = 17;

   // wide enough for a header start plus a full extension length
   localparam int SUM_W = EXT_W + 1;

   localparam logic [SUM_W-1:0] POS_MAX = SUM_W'((1 << POSITION_BITS) - 1);
   localparam logic [SUM_W-1:0] OFFSET_MAX = SUM_W'(16'hFFFF);
   localparam logic [SUM_W-1:0] EXT_MAX = SUM_W'(17'h1FFFF);
   localparam logic [EXT_W-1:0] V6_BASE_LEN = EXT_W'(40);

   localparam logic [1:0] ST_FOUND = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_NONFIRST = 2'd3;

   localparam logic [7:0] NH_HOPOPTS = 8'd0;
   localparam logic [7:0] NH_ROUTING = 8'd43;
   localparam logic [7:0] NH_FRAGMENT = 8'd44;
   localparam logic [7:0] NH_DSTOPTS = 8'd60;

   localparam logic [3:0] VER_IPV4 = 4'd4;
   localparam logic [3:0] VER_IPV6 = 4'd6;

   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] header_offset;
      logic [7:0]  protocol;
   } result_type;

endpackage

/* rtl/core/ip_upper_layer_header_locator.sv */
// IP upper-layer header locator.
// req channel: one packet byte per transaction, starting at the first byte of
// the IP header; req_tlast marks the final byte of the packet.
// rsp channel: one transaction per packet, issued for the final byte, giving
// the upper-layer protocol number, the byte offset of that header and a status
// (found, not IPv4/IPv6, truncated, non-first fragment).
// IPv4 takes protocol from byte 9 and the offset from IHL*4; IPv6 walks
// hop-by-hop, routing and destination options headers and stops at a
// fragment header or any other next-header value.
// Throughput: one byte per clock cycle while no held response is stalled by rsp_tready, with no gaps between
// packets; each byte passes an input register, one compare-and-add stage
// and the response register.
// The response is formed combinationally from the updated walk state and is registered
// in the response register.
// Reset clears the walk state and the valid bits of both registers; the next byte is read as
// the first byte of a packet. When rsp_tready is low with a response held,
// the pipeline stops and req_tready drops once the input register is full.
module ip_upper_layer_header_locator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packet_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] protocol, [23:8] header_offset, [25:24] status
);
   import ipul_pkg::*;

   logic       advance;
   logic       item_valid;
   item_type   item;
   logic       result_valid;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign advance = !rsp_valid_ff || rsp_tready;

   ipul_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ipul_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .fire         (item_valid && advance),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = result_valid;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

/* rtl/core/ipul_in_stage.sv */
module ipul_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              advance,
   output logic              item_valid,
   output ipul_pkg::item_type item
);
   import ipul_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = '{last: req_tlast, data: req_tdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/ipul_walker.sv */
module ipul_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  ipul_pkg::item_type  item,
   output logic                result_valid,
   output ipul_pkg::result_type result
);
   import ipul_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_V4 = 3'd1;
   localparam logic [2:0] PH_GAP = 3'd2;
   localparam logic [2:0] PH_HDR = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [3:0]               ver_ff, ver_in;
   logic [7:0]               cnh_ff, cnh_in;
   logic [EXT_W-1:0]         nes_ff, nes_in;
   logic [2:0]               phase_ff, phase_in;
   logic [15:0]              doff_ff, doff_in;
   logic [1:0]               dstat_ff, dstat_in;
   logic [12:0]              frag_ff, frag_in;
   logic [2:0]               win_ff, win_in;
   logic [7:0]               snh_ff, snh_in;
   logic [7:0]               slen_ff, slen_in;

   logic [7:0]     b;
   logic           hdr_byte;
   logic [2:0]     k;
   logic [SUM_W-1:0] nxt_raw;
   logic [SUM_W-1:0] nxt;
   logic [SUM_W-1:0] found_off;
   logic           found_req;

   assign b = item.data;

   always_comb begin
      pos_in    = pos_ff;
      ver_in    = ver_ff;
      cnh_in    = cnh_ff;
      nes_in    = nes_ff;
      phase_in  = phase_ff;
      doff_in   = doff_ff;
      dstat_in  = dstat_ff;
      frag_in   = frag_ff;
      win_in    = win_ff;
      snh_in    = snh_ff;
      slen_in   = slen_ff;
      hdr_byte  = 1'b0;
      k         = win_ff;
      found_req = 1'b0;
      found_off = '0;
      nxt_raw   = {1'b0, nes_ff} + SUM_W'(8) + {{(SUM_W-11){1'b0}}, slen_ff, 3'b000};
      nxt       = (nxt_raw > EXT_MAX) ? EXT_MAX : nxt_raw;

      case (phase_ff)
         PH_IDLE: begin
            ver_in = b[7:4];
            if (b[7:4] == VER_IPV4) begin
               doff_in  = {10'd0, b[3:0], 2'b00};
               phase_in = PH_V4;
            end else if (b[7:4] == VER_IPV6) begin
               nes_in   = V6_BASE_LEN;
               phase_in = PH_GAP;
            end else begin
               cnh_in   = '0;
               dstat_in = ST_UNKNOWN;
               doff_in  = '0;
               phase_in = PH_DONE;
            end
         end
         PH_V4: begin
            if (pos_ff == POSITION_BITS'(9)) begin
               cnh_in    = b;
               found_req = 1'b1;
               found_off = SUM_W'(doff_ff);
            end
         end
         PH_GAP: begin
            if (pos_ff == POSITION_BITS'(6)) begin
               cnh_in = b;
            end else if (EXT_W'(pos_ff) == nes_ff) begin
               phase_in = PH_HDR;
               k        = '0;
               hdr_byte = 1'b1;
            end
         end
         PH_HDR: begin
            hdr_byte = 1'b1;
         end
         default: begin
         end
      endcase

      if (hdr_byte) begin
         case (k)
            3'd0: snh_in = b;
            3'd1: slen_in = b;
            3'd2: frag_in = {b, 5'b00000};
            3'd3: frag_in = {frag_ff[12:5], b[7:3]};
            default: begin
            end
         endcase
         win_in = k + 3'd1;
         if (k == 3'd7) begin
            if (cnh_ff == NH_HOPOPTS || cnh_ff == NH_ROUTING || cnh_ff == NH_DSTOPTS) begin
               cnh_in = snh_ff;
               nes_in = nxt[EXT_W-1:0];
               if (nxt + SUM_W'(7) > POS_MAX) begin
                  dstat_in = ST_TRUNC;
                  doff_in  = '0;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_GAP;
               end
            end else if (cnh_ff == NH_FRAGMENT) begin
               cnh_in = snh_ff;
               if (frag_ff != '0) begin
                  dstat_in = ST_NONFIRST;
                  doff_in  = '0;
                  phase_in = PH_DONE;
               end else begin
                  found_req = 1'b1;
                  found_off = {1'b0, nes_ff} + SUM_W'(8);
               end
            end else begin
               found_req = 1'b1;
               found_off = {1'b0, nes_ff};
            end
         end
      end

      if (found_req) begin
         phase_in = PH_DONE;
         if (found_off > OFFSET_MAX) begin
            dstat_in = ST_TRUNC;
            doff_in  = '0;
         end else begin
            dstat_in = ST_FOUND;
            doff_in  = found_off[15:0];
         end
      end

      if (SUM_W'(pos_ff) < POS_MAX) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
   end

   // result of the byte in flight, taken from the updated walk state
   assign result_valid           = fire && item.last;
   assign result.protocol        = cnh_in;
   assign result.header_offset   = (phase_in == PH_DONE) ? doff_in : 16'd0;
   assign result.status          = (phase_in == PH_DONE) ? dstat_in : ST_TRUNC;

   always_ff @(posedge clock) begin
      if (reset || (fire && item.last)) begin
         pos_ff   <= '0;
         ver_ff   <= '0;
         cnh_ff   <= '0;
         nes_ff   <= V6_BASE_LEN;
         phase_ff <= PH_IDLE;
         doff_ff  <= '0;
         dstat_ff <= ST_TRUNC;
         frag_ff  <= '0;
         win_ff   <= '0;
         snh_ff   <= '0;
         slen_ff  <= '0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         ver_ff   <= ver_in;
         cnh_ff   <= cnh_in;
         nes_ff   <= nes_in;
         phase_ff <= phase_in;
         doff_ff  <= doff_in;
         dstat_ff <= dstat_in;
         frag_ff  <= frag_in;
         win_ff   <= win_in;
         snh_ff   <= snh_in;
         slen_ff  <= slen_in;
      end
   end

endmodule

/* test/ip_upper_layer_header_locator_checker.sv */
`timescale 1ns / 100ps
module ip_upper_layer_header_locator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packet_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [7:0] protocol, [23:8] header_offset, [25:24] status
   output int          failures,
   output int          pending
);
   import ipul_pkg::*;

   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_V4,
      WALK_GAP,
      WALK_HDR,
      WALK_DONE
   } walk_phase_e;

   localparam int POS_LIMIT = (1 << POSITION_BITS) - 1;
   localparam int EXT_LIMIT = 'h1FFFF;
   localparam int OFFSET_LIMIT = 'hFFFF;
   localparam int HDR_LEN = 8;
   localparam int IHL_UNIT = 4;
   localparam int V4_PROTO_POS = 9;
   localparam int V6_NEXT_HDR_POS = 6;

   walk_phase_e walk_phase;
   int          byte_pos;
   int          ext_start;
   int          chosen_offset;
   logic [1:0]  chosen_status;
   logic [3:0]  version;
   logic [7:0]  next_hdr;
   logic [7:0]  staged_next_hdr;
   logic [7:0]  staged_len;
   logic [12:0] frag_offset;
   logic [2:0]  window_idx;
   result_type  expected_results[$];

   function automatic void clear_walk();
      walk_phase = WALK_IDLE;
      byte_pos = 0;
      ext_start = V6_BASE_LEN;
      chosen_offset = 0;
      chosen_status = ST_TRUNC;
      version = '0;
      next_hdr = '0;
      staged_next_hdr = '0;
      staged_len = '0;
      frag_offset = '0;
      window_idx = '0;
   endfunction

   function automatic void settle(logic [1:0] status, int offset);
      if (status == ST_FOUND && offset > OFFSET_LIMIT) begin
         status = ST_TRUNC;
         offset = 0;
      end
      chosen_status = status;
      chosen_offset = offset;
      walk_phase = WALK_DONE;
   endfunction

   // one byte of the 8-byte window at the start of an ipv6 header
   function automatic void take_window_byte(logic [7:0] b);
      int following;
      case (window_idx)
         3'd0: staged_next_hdr = b;
         3'd1: staged_len = b;
         3'd2: frag_offset = {b, 5'b0};
         3'd3: frag_offset = {frag_offset[12:5], b[7:3]};
         default: ;
      endcase
      window_idx = window_idx + 3'd1;
      if (window_idx != 3'd0)
         return;
      if (next_hdr == NH_HOPOPTS || next_hdr == NH_ROUTING || next_hdr == NH_DSTOPTS) begin
         following = ext_start + HDR_LEN + int'(staged_len) * HDR_LEN;
         if (following > EXT_LIMIT)
            following = EXT_LIMIT;
         next_hdr = staged_next_hdr;
         ext_start = following;
         // the next header's window must still fit in the position range
         if (following + HDR_LEN - 1 > POS_LIMIT)
            settle(ST_TRUNC, 0);
         else
            walk_phase = WALK_GAP;
      end else if (next_hdr == NH_FRAGMENT) begin
         next_hdr = staged_next_hdr;
         if (frag_offset != '0)
            settle(ST_NONFIRST, 0);
         else
            settle(ST_FOUND, ext_start + HDR_LEN);
      end else begin
         settle(ST_FOUND, ext_start);
      end
   endfunction

   function automatic void take_packet_byte(logic [7:0] b);
      case (walk_phase)
         WALK_IDLE: begin
            version = b[7:4];
            if (version == VER_IPV4) begin
               chosen_offset = int'(b[3:0]) * IHL_UNIT;
               walk_phase = WALK_V4;
            end else if (version == VER_IPV6) begin
               ext_start = V6_BASE_LEN;
               walk_phase = WALK_GAP;
            end else begin
               next_hdr = '0;
               settle(ST_UNKNOWN, 0);
            end
         end
         WALK_V4: begin
            if (byte_pos == V4_PROTO_POS) begin
               next_hdr = b;
               settle(ST_FOUND, chosen_offset);
            end
         end
         WALK_GAP: begin
            if (byte_pos == V6_NEXT_HDR_POS) begin
               next_hdr = b;
            end else if (byte_pos == ext_start) begin
               walk_phase = WALK_HDR;
               window_idx = '0;
               take_window_byte(b);
            end
         end
         WALK_HDR: take_window_byte(b);
         default: ;
      endcase
      if (byte_pos < POS_LIMIT)
         byte_pos++;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want_result;
      result_type got_result;
      if (reset) begin
         clear_walk();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_result = rsp_tdata[$bits(result_type)-1:0];
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: result with none pending, expected nothing, actual %0d/%0d/%0d",
                        $time, got_result.protocol, got_result.header_offset,
                        got_result.status);
            end else begin
               want_result = expected_results.pop_front();
               compare_field("protocol", want_result.protocol, got_result.protocol);
               compare_field("header_offset", want_result.header_offset,
                             got_result.header_offset);
               compare_field("status", want_result.status, got_result.status);
            end
         end
         if (req_tvalid && req_tready) begin
            take_packet_byte(req_tdata);
            if (req_tlast) begin
               want_result.protocol = next_hdr;
               if (walk_phase == WALK_DONE) begin
                  want_result.header_offset = 16'(chosen_offset);
                  want_result.status = chosen_status;
               end else begin
                  want_result.header_offset = '0;
                  want_result.status = ST_TRUNC;
               end
               expected_results.push_back(want_result);
               clear_walk();
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

/* test/ip_upper_layer_header_locator_tb.sv */
`timescale 1ns / 100ps
module ip_upper_layer_header_locator_tb;
   import ipul_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_MIN_BYTES = 225;
   localparam int PHASE_MIN_PACKETS = 16;
   localparam int FULL_EXT_LEN = 255;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
   localparam logic [7:0] PROTO_NONE = 8'd59;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] packet_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [7:0] protocol, [23:8] header_offset, [25:24] status

   int          failures;
   int          pending;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_request = 1'b0;
   int          hold_left = 0;
   logic [7:0]  packet_bytes[$];

   ip_upper_layer_header_locator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ip_upper_layer_header_locator_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending);
         $display("ip_upper_layer_header_locator_tb: FAIL");
         $finish;
      end
   end

   // result side: random stalls, or a long hold-off once requested
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void push_random(int count);
      repeat (count) packet_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [7:0] pick_upper_proto();
      case ($urandom_range(4))
         0: return PROTO_TCP;
         1: return PROTO_UDP;
         2: return PROTO_ICMPV6;
         3: return PROTO_NONE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void build_ipv4();
      packet_bytes.delete();
      packet_bytes.push_back({VER_IPV4, 4'($urandom_range(15))});
      push_random($urandom_range(9, 40));
   endfunction

   // chain of full-size hop-by-hop headers, one sized header, then a first fragment
   function automatic void build_long(int full_headers, int last_len);
      packet_bytes.delete();
      packet_bytes.push_back({VER_IPV6, 4'h0});
      push_random(5);
      packet_bytes.push_back(NH_HOPOPTS);
      push_random(33);
      repeat (full_headers) begin
         packet_bytes.push_back(NH_HOPOPTS);
         packet_bytes.push_back(8'(FULL_EXT_LEN));
         push_random(6 + FULL_EXT_LEN * 8);
      end
      packet_bytes.push_back(NH_FRAGMENT);
      packet_bytes.push_back(8'(last_len));
      push_random(6 + last_len * 8);
      packet_bytes.push_back(PROTO_TCP);
      push_random(1);
      packet_bytes.push_back(8'h00);
      packet_bytes.push_back(8'h00);
      push_random(4 + 16);
   endfunction

   function automatic void build_random_packet();
      logic [7:0] chain[$];
      logic [3:0] odd_version;
      int         kind;
      int         ext_count;
      int         ext_len;
      int         cut;
      kind = $urandom_range(19);
      if (kind < 6) begin
         build_ipv4();
      end else if (kind < 15) begin
         ext_count = $urandom_range(3);
         repeat (ext_count) begin
            case ($urandom_range(2))
               0: chain.push_back(NH_HOPOPTS);
               1: chain.push_back(NH_ROUTING);
               default: chain.push_back(NH_DSTOPTS);
            endcase
         end
         chain.push_back(($urandom_range(2) == 0) ? NH_FRAGMENT : pick_upper_proto());
         packet_bytes.delete();
         packet_bytes.push_back({VER_IPV6, 4'($urandom_range(15))});
         push_random(5);
         packet_bytes.push_back(chain[0]);
         push_random(33);
         for (int i = 0; i < ext_count; i++) begin
            ext_len = ($urandom_range(9) == 0) ? $urandom_range(4, 40) : $urandom_range(2);
            packet_bytes.push_back(chain[i + 1]);
            packet_bytes.push_back(8'(ext_len));
            push_random(6 + ext_len * 8);
         end
         if (chain[ext_count] == NH_FRAGMENT) begin
            packet_bytes.push_back(pick_upper_proto());
            push_random(1);
            case ($urandom_range(3))
               // first fragment, only the flag bits set
               0: begin
                  packet_bytes.push_back(8'h00);
                  packet_bytes.push_back(8'($urandom_range(7)));
               end
               1: begin
                  packet_bytes.push_back(8'($urandom_range(1, 255)));
                  push_random(1);
               end
               // offset only in the top bits of the fourth byte
               2: begin
                  packet_bytes.push_back(8'h00);
                  packet_bytes.push_back({5'($urandom_range(1, 31)), 3'($urandom_range(7))});
               end
               default: push_random(2);
            endcase
            push_random(4);
         end else begin
            push_random(8);
         end
         push_random($urandom_range(8));
      end else if (kind < 17) begin
         odd_version = 4'($urandom_range(13));
         if (odd_version >= VER_IPV4)
            odd_version++;
         if (odd_version >= VER_IPV6)
            odd_version++;
         packet_bytes.delete();
         packet_bytes.push_back({odd_version, 4'($urandom_range(15))});
         push_random($urandom_range(4));
      end else begin
         packet_bytes.delete();
         push_random($urandom_range(1, 48));
      end
      if ($urandom_range(3) == 0) begin
         cut = $urandom_range(1, packet_bytes.size());
         packet_bytes = packet_bytes[0:cut-1];
      end
   endfunction

   task automatic send_item(logic [7:0] data, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (packet_bytes[i])
         send_item(packet_bytes[i], i == packet_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic set_phase(int idle_pct, int stall_pct);
      req_tvalid <= 1'b0;
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      @(negedge clock);
   endtask

   task automatic run_random_phase(int idle_pct, int stall_pct);
      int sent_bytes;
      int sent_packets;
      sent_bytes = 0;
      sent_packets = 0;
      set_phase(idle_pct, stall_pct);
      while (sent_bytes < PHASE_MIN_BYTES || sent_packets < PHASE_MIN_PACKETS) begin
         build_random_packet();
         sent_bytes += packet_bytes.size();
         sent_packets++;
         send_packet();
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_phase(0, 0);

      // unknown versions, the smallest and largest byte
      packet_bytes = '{8'h00};
      send_packet();
      packet_bytes = '{8'hFF};
      send_packet();
      // ipv4 cut off before the protocol byte
      packet_bytes = '{{VER_IPV4, 4'h5}, 8'h00, 8'hFF};
      send_packet();
      // ipv4 with an ihl of zero, reported as is
      packet_bytes = '{{VER_IPV4, 4'h0}};
      push_random(8);
      packet_bytes.push_back(8'hFF);
      send_packet();
      // ipv6 ending one byte after the next header byte
      packet_bytes = '{{VER_IPV6, 4'hF}};
      push_random(5);
      packet_bytes.push_back(PROTO_TCP);
      packet_bytes.push_back(8'hFF);
      send_packet();
      wait_drained();

      // results held back while short packets keep coming
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      repeat (8) begin
         build_ipv4();
         send_packet();
      end
      wait_drained();

      // found offset just past the 16-bit range, then a header start beyond it
      build_long(31, 249);
      send_packet();
      build_long(31, FULL_EXT_LEN);
      send_packet();
      wait_drained();

      run_random_phase(0, 0);
      run_random_phase(65, 0);
      run_random_phase(0, 65);
      run_random_phase(36, 36);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ip_upper_layer_header_locator_tb: PASS");
      end else begin
         $display("ip_upper_layer_header_locator_tb: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ipul_pkg.sv
rtl/core/ipul_in_stage.sv
rtl/core/ipul_walker.sv
rtl/core/ip_upper_layer_header_locator.sv
test/ip_upper_layer_header_locator_checker.sv
test/ip_upper_layer_header_locator_tb.sv
